[sv/cell_exit_face_finder_unit_defines.svh]
// Assertion macros shared by the exit face finder modules.
// Depends on nothing; the using module must have signals named clock and reset.
`ifndef CELL_EXIT_FACE_FINDER_UNIT_DEFINES_SVH
`define CELL_EXIT_FACE_FINDER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Concurrent property checked every cycle outside reset.
`define CEFU_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define CEFU_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`else

`define CEFU_ASSERT(lbl, prop, msg)
`define CEFU_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

[sv/cefu_pkg.sv]
// Types and constants shared by the exit face finder modules.
// Depends on nothing.
`timescale 1ns / 1ps

package cefu_pkg;

   // Field widths of the fixed-point arithmetic.
   localparam int COORD_W   = 32;
   localparam int DIFF_W    = 33;
   localparam int PROD_W    = 66;
   localparam int NUM_W     = 67;
   localparam int DEN_W     = 66;
   localparam int FRAC_W    = 16;
   localparam int QUO_W     = 33;
   localparam int LOW_W     = QUO_W - FRAC_W;
   localparam int FACE_W    = 3;
   localparam int DIMS_W    = 2;
   localparam int COMP_N    = 3;
   localparam int STEP_W    = 3;
   localparam int DIV_CNT_W = 6;

   // Sequencer limits.
   localparam logic [STEP_W-1:0]    LAST_STEP = 3'd5;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST  = 6'd32;

   // Request kinds.
   localparam logic KIND_PARTICLE = 1'b0;
   localparam logic KIND_FACE     = 1'b1;

   // Time limits and reset values.
   localparam logic signed [COORD_W-1:0] TIME_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] TIME_MIN  = 32'sh8000_0000;
   localparam logic [QUO_W-1:0]          NEG_LIMIT = 33'h0_8000_0000;
   localparam logic [DIMS_W-1:0]         DIMS_RESET = 2'd3;

   typedef struct packed {
      logic                      kind;
      logic signed [COORD_W-1:0] a_x;
      logic signed [COORD_W-1:0] a_y;
      logic signed [COORD_W-1:0] a_z;
      logic signed [COORD_W-1:0] b_x;
      logic signed [COORD_W-1:0] b_y;
      logic signed [COORD_W-1:0] b_z;
      logic                      last_face;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] hit_time;
      logic [FACE_W-1:0]         face_index;
      logic                      not_found;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_DRAIN,
      ST_SIGN,
      ST_DCHK,
      ST_DIV,
      ST_SAT,
      ST_UPD,
      ST_FIN,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic       mul_den;
      logic [1:0] mul_comp;
      logic       mag;
      logic       div_init;
      logic       div_step;
      logic       sat;
      logic       upd;
      logic       count;
      logic       emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic den_pos;
      logic last;
      logic out_busy;
   } sts_type;

endpackage

[sv/cefu_ctrl.sv]
// Controller state machine of the exit face finder: sequences the products,
// the divider and the result. Depends on cefu_pkg and the defines header.
`timescale 1ns / 1ps
`include "cell_exit_face_finder_unit_defines.svh"

module cefu_ctrl
   import cefu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_kind,
   output logic    req_ready,
   output cmd_type cmd,
   input  sts_type sts
);

   state_type              state_ff, state_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_kind == KIND_FACE) begin
               state_in = sts.full ? ST_FIN : ST_MUL;
            end
         end
         ST_MUL: begin
            if (step_ff == LAST_STEP) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_SIGN;
         ST_SIGN:  state_in = sts.den_pos ? ST_DCHK : ST_FIN;
         ST_DCHK:  state_in = ST_DIV;
         ST_DIV: begin
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT:   state_in = ST_UPD;
         ST_UPD:   state_in = ST_FIN;
         ST_FIN:   state_in = sts.last ? ST_EMIT : ST_IDLE;
         ST_EMIT: begin
            if (!sts.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Product step and divider iteration counters.
   always_comb begin
      step_in    = (state_ff == ST_MUL) ? step_ff + 1'b1 : '0;
      div_cnt_in = (state_ff == ST_DIV) ? div_cnt_ff + 1'b1 : '0;
   end

   // Outputs decoded from the state.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_MUL: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_den  = step_ff[0];
            cmd.mul_comp = step_ff[2:1];
         end
         ST_SIGN: cmd.mag      = 1'b1;
         ST_DCHK: cmd.div_init = 1'b1;
         ST_DIV:  cmd.div_step = 1'b1;
         ST_SAT:  cmd.sat      = 1'b1;
         ST_UPD:  cmd.upd      = 1'b1;
         ST_FIN:  cmd.count    = 1'b1;
         ST_EMIT: cmd.emit     = !sts.out_busy;
         default: cmd          = '0;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         step_ff    <= '0;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         step_ff    <= step_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   // A result is only loaded when the output register can take it.
   `CEFU_ASSERT(a_emit_free, cmd.emit |-> !sts.out_busy, "emit while output busy")
   // The sixth product is followed by the drain cycle.
   `CEFU_ASSERT_NEXT(a_mul_drain, state_ff == ST_MUL && step_ff == LAST_STEP,
      state_ff == ST_DRAIN, "product sequence overran")
   // The last divider step is followed by saturation.
   `CEFU_ASSERT_NEXT(a_div_sat, state_ff == ST_DIV && div_cnt_ff == DIV_LAST,
      cmd.sat, "divider did not finish")

endmodule

[sv/cefu_datapath.sv]
// Datapath of the exit face finder: vector registers, shared multiplier,
// accumulators, restoring divider, best-face search and output register.
// Depends on cefu_pkg and the defines header.
`timescale 1ns / 1ps
`include "cell_exit_face_finder_unit_defines.svh"

module cefu_datapath
   import cefu_pkg::*;
#(
   parameter int MAX_FACES = 8
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [DIMS_W-1:0] csr_wr_data,
   input  req_type           req_data,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output rsp_type           rsp_data
);

   localparam int CNT_W = $clog2(MAX_FACES + 1);

   logic [DIMS_W-1:0]         dims_ff, dims_in;
   logic signed [COORD_W-1:0] pos_ff [COMP_N];
   logic signed [COORD_W-1:0] pos_in [COMP_N];
   logic signed [COORD_W-1:0] vel_ff [COMP_N];
   logic signed [COORD_W-1:0] vel_in [COMP_N];
   logic signed [COORD_W-1:0] nrm_ff [COMP_N];
   logic signed [COORD_W-1:0] nrm_in [COMP_N];
   logic signed [DIFF_W-1:0]  dif_ff [COMP_N];
   logic signed [DIFF_W-1:0]  dif_in [COMP_N];
   logic signed [COORD_W-1:0] req_a  [COMP_N];
   logic signed [COORD_W-1:0] req_b  [COMP_N];
   logic                      last_ff, last_in;

   logic signed [DIFF_W-1:0]  op_a, op_b;
   logic                      use_comp;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic                      prod_vld_ff, prod_vld_in;
   logic                      prod_den_ff, prod_den_in;
   logic signed [NUM_W-1:0]   num_ff, num_in;
   logic signed [DEN_W-1:0]   den_ff, den_in;

   logic                      neg_ff, neg_in;
   logic [NUM_W-1:0]          mag_ff, mag_in;
   logic [DEN_W-1:0]          dvsr;
   logic [DEN_W-1:0]          hi_part;
   logic [DEN_W-1:0]          rem_ff, rem_in;
   logic [QUO_W-1:0]          quo_ff, quo_in;
   logic                      ovf_ff, ovf_in;
   logic [DEN_W:0]            trial, trial_sub;
   logic                      trial_ge;
   logic signed [COORD_W-1:0] t_ff, t_in;

   logic signed [COORD_W-1:0] best_time_ff, best_time_in;
   logic [FACE_W-1:0]         best_face_ff, best_face_in;
   logic                      found_ff, found_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      load_particle, load_face, better;

   rsp_type                   rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // Request components as arrays.
   always_comb begin
      req_a[0] = req_data.a_x;
      req_a[1] = req_data.a_y;
      req_a[2] = req_data.a_z;
      req_b[0] = req_data.b_x;
      req_b[1] = req_data.b_y;
      req_b[2] = req_data.b_z;
   end

   assign load_particle = cmd.load && req_data.kind == KIND_PARTICLE;
   assign load_face     = cmd.load && req_data.kind == KIND_FACE;

   // Configuration and request capture; the face point is stored relative
   // to the particle position.
   always_comb begin
      dims_in = csr_wr_en ? csr_wr_data : dims_ff;
      last_in = load_face ? req_data.last_face : last_ff;
      for (int i = 0; i < COMP_N; i++) begin
         pos_in[i] = load_particle ? req_a[i] : pos_ff[i];
         vel_in[i] = load_particle ? req_b[i] : vel_ff[i];
         nrm_in[i] = load_face ? req_a[i] : nrm_ff[i];
         dif_in[i] = load_face ? DIFF_W'(req_b[i]) - DIFF_W'(pos_ff[i]) : dif_ff[i];
      end
   end

   // Shared multiplier operand selection by component.
   always_comb begin
      op_a = '0;
      op_b = '0;
      for (int i = 0; i < COMP_N; i++) begin
         if (cmd.mul_comp == 2'(i)) begin
            op_a = DIFF_W'(nrm_ff[i]);
            op_b = cmd.mul_den ? DIFF_W'(vel_ff[i]) : dif_ff[i];
         end
      end
   end

   assign use_comp    = cmd.mul_comp < dims_ff;
   assign prod_in     = op_a * op_b;
   assign prod_vld_in = cmd.mul_en && use_comp;
   assign prod_den_in = cmd.mul_den;

   // Accumulate the registered product into numerator or denominator.
   always_comb begin
      num_in = num_ff;
      den_in = den_ff;
      if (load_face) begin
         num_in = '0;
         den_in = '0;
      end else if (prod_vld_ff && prod_den_ff) begin
         den_in = den_ff + DEN_W'(prod_ff);
      end else if (prod_vld_ff) begin
         num_in = num_ff + NUM_W'(prod_ff);
      end
   end

   // Sign and magnitude of the numerator.
   always_comb begin
      neg_in = cmd.mag ? num_ff[NUM_W-1] : neg_ff;
      mag_in = mag_ff;
      if (cmd.mag) begin
         mag_in = NUM_W'(num_ff[NUM_W-1] ? -num_ff : num_ff);
      end
   end

   // Restoring divider of (magnitude * 2^16) by the denominator. The upper
   // dividend bits are checked once for a quotient that cannot fit, then
   // one quotient bit is produced per cycle.
   assign dvsr      = den_ff;
   assign hi_part   = DEN_W'(mag_ff[NUM_W-1:LOW_W]);
   assign trial     = {rem_ff, quo_ff[QUO_W-1]};
   assign trial_ge  = trial >= {1'b0, dvsr};
   assign trial_sub = trial - {1'b0, dvsr};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      ovf_in = ovf_ff;
      if (cmd.div_init) begin
         ovf_in = hi_part >= dvsr;
         rem_in = hi_part;
         quo_in = {mag_ff[LOW_W-1:0], {FRAC_W{1'b0}}};
      end else if (cmd.div_step) begin
         rem_in = trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], trial_ge};
      end
   end

   // Apply the sign and saturate the quotient to 32 bits.
   always_comb begin
      t_in = t_ff;
      if (cmd.sat) begin
         if (neg_ff) begin
            t_in = (ovf_ff || quo_ff > NEG_LIMIT) ? TIME_MIN
                                                  : -$signed(quo_ff[COORD_W-1:0]);
         end else begin
            t_in = (ovf_ff || quo_ff[QUO_W-1:COORD_W-1] != '0) ? TIME_MAX
                                                               : $signed(quo_ff[COORD_W-1:0]);
         end
      end
   end

   // Best face search, face counter and search clear.
   assign better = !found_ff || (t_ff < best_time_ff);

   always_comb begin
      best_time_in = best_time_ff;
      best_face_in = best_face_ff;
      found_in     = found_ff;
      count_in     = count_ff;
      if (cmd.upd && better) begin
         best_time_in = t_ff;
         best_face_in = FACE_W'(count_ff);
         found_in     = 1'b1;
      end
      if (cmd.count && !sts.full) begin
         count_in = count_ff + 1'b1;
      end
      if (load_particle || cmd.emit) begin
         best_time_in = TIME_MAX;
         best_face_in = '0;
         found_in     = 1'b0;
         count_in     = '0;
      end
   end

   // Output register.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_in.hit_time   = best_time_ff;
         rsp_in.face_index = best_face_ff;
         rsp_in.not_found  = !found_ff;
         rsp_valid_in      = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Status toward the controller.
   always_comb begin
      sts.full     = count_ff == CNT_W'(MAX_FACES);
      sts.den_pos  = !den_ff[DEN_W-1] && den_ff != '0;
      sts.last     = last_ff;
      sts.out_busy = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Registers with reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff      <= DIMS_RESET;
         best_time_ff <= TIME_MAX;
         best_face_ff <= '0;
         found_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         prod_vld_ff  <= 1'b0;
         for (int i = 0; i < COMP_N; i++) begin
            pos_ff[i] <= '0;
            vel_ff[i] <= '0;
         end
      end else begin
         dims_ff      <= dims_in;
         best_time_ff <= best_time_in;
         best_face_ff <= best_face_in;
         found_ff     <= found_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         prod_vld_ff  <= prod_vld_in;
         for (int i = 0; i < COMP_N; i++) begin
            pos_ff[i] <= pos_in[i];
            vel_ff[i] <= vel_in[i];
         end
      end
   end

   // Working registers without reset.
   always_ff @(posedge clock) begin
      for (int i = 0; i < COMP_N; i++) begin
         nrm_ff[i] <= nrm_in[i];
         dif_ff[i] <= dif_in[i];
      end
      last_ff     <= last_in;
      prod_ff     <= prod_in;
      prod_den_ff <= prod_den_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      ovf_ff      <= ovf_in;
      t_ff        <= t_in;
      rsp_ff      <= rsp_in;
   end

   // The face counter stops at the face limit.
   `CEFU_ASSERT(a_count_max, count_ff <= CNT_W'(MAX_FACES), "face count past limit")
   // Without overflow the partial remainder stays below the divisor.
   `CEFU_ASSERT(a_rem_bound, cmd.div_step && !ovf_ff |-> rem_ff < dvsr,
      "divider remainder out of range")
   // A not-found result carries the maximum time.
   `CEFU_ASSERT(a_none_max, rsp_valid_ff && rsp_ff.not_found |-> rsp_ff.hit_time == TIME_MAX,
      "not found result with wrong time")

endmodule

[sv/cell_exit_face_finder_unit.sv]
// A particle request loads while idle. A face with positive n.V runs the product, drain,
// sign, divider check, 33-step restoring divider, saturation, update and finish states;
// other faces go from sign to finish, faces past the limit straight to finish. A last
// face adds an emit state that loads its result into the output register when it is not
// busy; the next request is taken while that result waits. Reset is synchronous, active
// high: dims returns to 3; position, velocity and search state clear; it is ready at once.
`timescale 1ns / 1ps

module cell_exit_face_finder_unit
   import cefu_pkg::*;
#(
   parameter int MAX_FACES = 8
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [DIMS_W-1:0] csr_wr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data
);

   cmd_type cmd;
   sts_type sts;

   // Sequencing of each request.
   cefu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Arithmetic, search state and output register.
   cefu_datapath #(
      .MAX_FACES (MAX_FACES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule
